@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the identifier set block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define BIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define BIS_NEVER(lbl, cond, msg) \
    `BIS_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/bis_pkg.sv @@
// Shared types and constants for the bounded identifier set.
// No dependencies.
package bis_pkg;

    // Request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // Configuration port
    localparam int unsigned APB_AW            = 3;
    localparam logic        REG_RESERVED_ID   = 1'b0;   // word select, paddr[2]
    localparam logic [31:0] RESERVED_ID_RESET = 32'hFFFF_FFFF;

    // Result field widths
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COUNT_W = 7;

endpackage

@@ rtl/core/bis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bis_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bounded_id_set.sv @@
// Bounded identifier set: top level, sequencer and configuration port.
// Depends on bis_pkg, bis_ram and assert_macros.svh.
//
// Holds up to CAPACITY distinct 32-bit identifiers packed in one RAM with a
// count. Add, delete and membership query walk the RAM from slot 0, one entry
// per cycle through its single read port. A miss scans every slot below the count;
// a hit in slot k ends the scan there, and a delete that hits spends a move state
// on moving the last entry into the hole. With an empty set or the reserved id
// there is nothing to scan. A read by position waits for the RAM read data, or
// goes straight to the result state when the position is out of range. One request
// is in flight at a time; in_stall is high until its result has been handed to the
// output register, and the next request can be taken once the sequencer is back in
// idle. A stalled output register holds the sequencer in its last state and so
// stretches the stall on the input. The user must write reserved_id over the APB
// port only while idle; the block itself does not enforce it. The RAM needs no
// clearing after reset: only slots below the count are ever read.
module bounded_id_set
    import bis_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [31:0]        element_id,
    input  logic [POS_W-1:0]   position,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic               found,
    output logic [POS_W-1:0]   found_position,
    output logic [31:0]        read_id,
    output logic [COUNT_W-1:0] count,
    output logic               is_empty,
    output logic               is_full,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_MOVE,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

    state_t              state_reg,    state_next;
    logic [CW-1:0]       count_reg,    count_next;
    logic [AW-1:0]       idx_reg,      idx_next;
    req_t                req_reg,      req_next;
    logic [31:0]         id_reg,       id_next;
    logic                hit_reg,      hit_next;
    logic [AW-1:0]       slot_reg,     slot_next;
    logic                status_reg,   status_next;
    logic [31:0]         rid_reg,      rid_next;
    logic [31:0]         reserved_reg, reserved_next;

    logic                out_valid_reg,  out_valid_next;
    logic                o_status_reg,   o_status_next;
    logic                o_found_reg,    o_found_next;
    logic [POS_W-1:0]    o_pos_reg,      o_pos_next;
    logic [31:0]         o_rid_reg,      o_rid_next;
    logic [COUNT_W-1:0]  o_count_reg,    o_count_next;
    logic                o_empty_reg,    o_empty_next;
    logic                o_full_reg,     o_full_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [31:0]         ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata;

    logic [31:0]         slot_wide;
    logic [31:0]         count_wide;
    logic                in_accept;
    logic                cfg_write;
    logic                more;
    logic                count_step_ok;

    // Entry storage
    bis_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign slot_wide  = 32'(slot_reg);
    assign count_wide = 32'(count_reg);
    // another slot left below the count to scan
    assign more       = (32'(idx_reg) + 32'd1) < count_wide;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_RESERVED_ID) ? reserved_reg : 32'd0;

    // Sequencer next state, RAM control and result staging
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        reserved_next  = reserved_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_status_next  = o_status_reg;
        o_found_next   = o_found_reg;
        o_pos_next     = o_pos_reg;
        o_rid_next     = o_rid_reg;
        o_count_next   = o_count_reg;
        o_empty_next   = o_empty_reg;
        o_full_next    = o_full_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = id_reg;
        ram_raddr      = idx_reg;

        if (cfg_write && (paddr[2] == REG_RESERVED_ID))
        begin
            reserved_next = pwdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next    = req_t'(req_type);
                    id_next     = element_id;
                    hit_next    = 1'b0;
                    slot_next   = '0;
                    idx_next    = '0;
                    status_next = 1'b0;
                    rid_next    = reserved_reg;
                    if (req_t'(req_type) == REQ_READ)
                    begin
                        if (32'(position) < count_wide)
                        begin
                            ram_raddr  = AW'(position);
                            state_next = ST_READ_WAIT;
                        end
                        else
                        begin
                            status_next = 1'b1;
                            state_next  = ST_RESULT;
                        end
                    end
                    else if ((element_id == reserved_reg) || (count_reg == '0))
                    begin
                        // nothing to scan: id cannot be present
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end

            // read data holds entries[idx_reg]; the next address is issued in this state
            ST_SEARCH:
            begin
                if (ram_rdata == id_reg)
                begin
                    hit_next   = 1'b1;
                    slot_next  = idx_reg;
                    state_next = ST_APPLY;
                end
                else if (more)
                begin
                    idx_next   = idx_reg + AW'(1);
                    ram_raddr  = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                state_next = ST_RESULT;
                case (req_reg)
                    REQ_ADD:
                    begin
                        if ((id_reg == reserved_reg) || (count_reg == CW'(CAPACITY)))
                        begin
                            status_next = 1'b1;
                        end
                        else if (!hit_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = AW'(count_reg);
                            ram_wdata  = id_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            // fetch the last entry to fill the hole
                            count_next = count_reg - CW'(1);
                            ram_raddr  = AW'(count_reg - CW'(1));
                            state_next = ST_MOVE;
                        end
                    end
                    default:
                    begin
                        status_next = 1'b0;
                    end
                endcase
            end

            ST_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_RESULT;
            end

            ST_READ_WAIT:
            begin
                rid_next   = ram_rdata;
                state_next = ST_RESULT;
            end

            // hand the staged word to the output register once it is free
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_found_next   = hit_reg;
                    o_pos_next     = hit_reg ? slot_wide[POS_W-1:0] : '0;
                    o_rid_next     = rid_reg;
                    o_count_next   = count_wide[COUNT_W-1:0];
                    o_empty_next   = (count_reg == '0);
                    o_full_next    = (count_reg == CW'(CAPACITY));
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            reserved_reg  <= RESERVED_ID_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            reserved_reg  <= reserved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        id_reg       <= id_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        rid_reg      <= rid_next;
        o_status_reg <= o_status_next;
        o_found_reg  <= o_found_next;
        o_pos_reg    <= o_pos_next;
        o_rid_reg    <= o_rid_next;
        o_count_reg  <= o_count_next;
        o_empty_reg  <= o_empty_next;
        o_full_reg   <= o_full_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign found          = o_found_reg;
    assign found_position = o_pos_reg;
    assign read_id        = o_rid_reg;
    assign count          = o_count_reg;
    assign is_empty       = o_empty_reg;
    assign is_full        = o_full_reg;

    // count moves by at most one per cycle
    assign count_step_ok = (count_next == count_reg)
                        || (count_next == count_reg + CW'(1))
                        || (count_next == count_reg - CW'(1));

    // Checks
`include "assert_macros.svh"

    `BIS_NEVER(a_count_bound, 32'(count_reg) > CAPACITY, "element count above capacity")
    `BIS_ASSERT(a_count_step, count_step_ok, "count moved by more than one")
    `BIS_ASSERT(a_scan_range, (state_reg == ST_SEARCH) |-> (32'(idx_reg) < count_wide), "search index beyond count")
    `BIS_NEVER(a_idle_write, ram_we && (state_reg == ST_IDLE), "RAM written while idle")

endmodule

@@ tb/bounded_id_set_test.sv @@
// Self-checking testbench for bounded_id_set: drives request words, predicts each
// result word from its own set model and checks every field as results arrive.
// Depends on bis_pkg and the bounded_id_set RTL.
`timescale 1ns / 100ps

module bounded_id_set_test;
    import bis_pkg::*;

    localparam int unsigned SET_CAP     = 64;
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned DRAIN_WAIT  = SET_CAP + 40;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned IDLE_PCT    = 21;

    // One expected result word
    typedef struct packed {
        logic               status;
        logic               found;
        logic [POS_W-1:0]   found_position;
        logic [31:0]        read_id;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } set_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = REQ_QUERY;
    logic [31:0]        element_id = '0;
    logic [POS_W-1:0]   position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               status;
    logic               found;
    logic [POS_W-1:0]   found_position;
    logic [31:0]        read_id;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Set model: packed ids, count and the current reserved id
    logic [31:0]        model_ids [SET_CAP];
    int unsigned        model_count;
    logic [31:0]        model_reserved;

    set_result_t        pending_results [$];
    set_result_t        want_word;
    int unsigned        mismatches = 0;
    int unsigned        cycles = 0;
    bit                 calm = 1'b0;
    int unsigned        hold_requests = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;

    bounded_id_set #(.CAPACITY(SET_CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .element_id(element_id), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found(found), .found_position(found_position),
        .read_id(read_id), .count(count), .is_empty(is_empty), .is_full(is_full),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[bounded_id_set] ERROR");
            $finish;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Applies one request to the set model and returns the result word it gives
    function automatic set_result_t apply_request(req_t rq, logic [31:0] id,
                                                  logic [POS_W-1:0] pos);
        set_result_t r;
        bit          hit;
        int unsigned slot;
        r = '0;
        r.read_id = model_reserved;
        hit = 1'b0;
        slot = 0;
        // linear search below the count; the reserved id never matches
        if (rq != REQ_READ && id != model_reserved)
            for (int unsigned i = 0; i < model_count; i++)
                if (!hit && model_ids[i] == id)
                begin
                    hit = 1'b1;
                    slot = i;
                end
        case (rq)
            REQ_ADD:
                if (id == model_reserved || model_count >= SET_CAP)
                    r.status = 1'b1;
                else if (!hit)
                begin
                    model_ids[model_count] = id;
                    model_count++;
                end
            REQ_DELETE:
                if (!hit)
                    r.status = 1'b1;
                else
                begin
                    // last entry fills the hole
                    model_count--;
                    model_ids[slot] = model_ids[model_count];
                end
            REQ_READ:
                if (pos < model_count)
                    r.read_id = model_ids[pos];
                else
                    r.status = 1'b1;
            default: ;
        endcase
        r.found = hit;
        r.found_position = hit ? slot[POS_W-1:0] : '0;
        r.count = model_count[COUNT_W-1:0];
        r.is_empty = (model_count == 0);
        r.is_full = (model_count == SET_CAP);
        return r;
    endfunction

    // Offers one request word, holds it until taken, then records its prediction
    task automatic send_word(req_t rq, logic [31:0] id, logic [POS_W-1:0] pos);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        element_id <= id;
        position   <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_request(rq, id, pos));
    endtask

    // Lets every outstanding result drain before the set is reconfigured
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_read_check(logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes reserved_id (word 0) and reads it back
    task automatic write_reserved(logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({REG_RESERVED_ID, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        model_reserved = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        apb_read_check(value);
    endtask

    // Picks an id: a stored one, the reserved one now and then, else any value
    function automatic logic [31:0] pick_id(int unsigned present_pct);
        if (model_count > 0 && $urandom_range(99) < present_pct)
            return model_ids[$urandom_range(model_count - 1)];
        if ($urandom_range(99) < 5)
            return model_reserved;
        return $urandom;
    endfunction

    // Random traffic with the given mix of adds and deletes; the rest split
    // between queries and reads by position
    task automatic run_phase(int unsigned n, int unsigned add_pct, int unsigned del_pct);
        int unsigned      roll;
        logic [POS_W-1:0] pos;
        for (int unsigned k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (model_count > 0 && $urandom_range(1))
                pos = POS_W'($urandom_range(model_count - 1));
            else
                pos = POS_W'($urandom_range(SET_CAP - 1));
            if (roll < add_pct)
                send_word(REQ_ADD, pick_id(25), pos);
            else if (roll < add_pct + del_pct)
                send_word(REQ_DELETE, pick_id(85), pos);
            else if (roll < add_pct + del_pct + (100 - add_pct - del_pct) / 2)
                send_word(REQ_QUERY, pick_id(60), pos);
            else
                send_word(REQ_READ, $urandom, pos);
        end
    endtask

    // Result checker: each word taken is compared with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatches++;
            end
            else
            begin
                want_word = pending_results.pop_front();
                check_field("status", want_word.status, status);
                check_field("found", want_word.found, found);
                check_field("found_position", want_word.found_position, found_position);
                check_field("read_id", want_word.read_id, read_id);
                check_field("count", want_word.count, count);
                check_field("is_empty", want_word.is_empty, is_empty);
                check_field("is_full", want_word.is_full, is_full);
            end
        end
    end

    // Result sink: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic test_register_reset();
        apb_read_check(RESERVED_ID_RESET);
        @(posedge clk);
    endtask

    // Empty set, reserved id, duplicates, field extremes and the swap on delete
    task automatic test_directed_basics();
        send_word(REQ_QUERY,  32'h0000_0000, 6'd63);
        send_word(REQ_DELETE, 32'h1234_5678, 6'd0);
        send_word(REQ_READ,   32'hFFFF_FFFF, 6'd0);
        send_word(REQ_READ,   32'h0000_0000, 6'd63);
        send_word(REQ_ADD,    32'hFFFF_FFFF, 6'd0);
        send_word(REQ_DELETE, 32'hFFFF_FFFF, 6'd63);
        send_word(REQ_QUERY,  32'hFFFF_FFFF, 6'd0);
        send_word(REQ_ADD,    32'h0000_0000, 6'd63);
        send_word(REQ_ADD,    32'hFFFF_FFFE, 6'd0);
        send_word(REQ_ADD,    32'hA5A5_5A5A, 6'd21);
        send_word(REQ_ADD,    32'h0000_0000, 6'd42);
        send_word(REQ_QUERY,  32'hFFFF_FFFE, 6'd0);
        send_word(REQ_READ,   32'h5A5A_A5A5, 6'd2);
        send_word(REQ_READ,   32'h0000_0000, 6'd3);
        send_word(REQ_DELETE, 32'h0000_0000, 6'd0);
        send_word(REQ_READ,   32'h0000_0000, 6'd0);
        send_word(REQ_QUERY,  32'h0000_0000, 6'd63);
    endtask

    // Reserved id moved onto a stored entry, then to zero
    task automatic test_reserved_change();
        write_reserved(32'hFFFF_FFFE);
        send_word(REQ_QUERY,  32'hFFFF_FFFE, 6'd0);
        send_word(REQ_DELETE, 32'hFFFF_FFFE, 6'd0);
        send_word(REQ_READ,   32'h0000_0000, 6'd1);
        send_word(REQ_ADD,    32'hFFFF_FFFE, 6'd0);
        send_word(REQ_ADD,    32'hFFFF_FFFF, 6'd0);
        send_word(REQ_QUERY,  32'hFFFF_FFFF, 6'd0);
        write_reserved(32'h0000_0000);
        send_word(REQ_ADD,    32'h0000_0000, 6'd0);
        send_word(REQ_DELETE, 32'hFFFF_FFFE, 6'd0);
        send_word(REQ_READ,   32'h0000_0000, 6'd1);
    endtask

    // Sink holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_requests++;
        run_phase(12, 40, 20);
    endtask

    // Fill to capacity and past it, then drain, under the reset reserved id
    task automatic test_fill_and_drain();
        write_reserved(32'hFFFF_FFFF);
        run_phase(200, 70, 10);
        run_phase(150, 10, 65);
    endtask

    // Balanced traffic with no idling on either side
    task automatic test_quiet_mix();
        write_reserved($urandom);
        calm = 1'b1;
        run_phase(150, 35, 30);
        calm = 1'b0;
    endtask

    // Reserved id taken from a stored entry, then a second fill and drain
    task automatic test_reserved_stored_random();
        wait_idle();
        write_reserved(model_count > 0 ? model_ids[$urandom_range(model_count - 1)]
                                       : 32'h0000_0000);
        run_phase(150, 70, 10);
        run_phase(100, 15, 60);
    endtask

    initial
    begin
        model_count = 0;
        model_reserved = RESERVED_ID_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_basics();
        test_reserved_change();
        test_backpressure();
        test_fill_and_drain();
        test_quiet_mix();
        test_reserved_stored_random();

        // let the last results drain, then watch for strays
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[bounded_id_set] OK");
        else
            $display("[bounded_id_set] ERROR");
        $finish;
    end

endmodule
